/* sv/mvt_pkg.sv */
`default_nettype none

package mvt_pkg;

    localparam int ROWS    = 4;
    localparam int COLS    = 4;
    localparam int NUM_Y   = 4;
    localparam int NUM_X   = 4;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int Q_SHIFT = 16;
    localparam int Q_W     = SUM_W - Q_SHIFT;
    localparam int CNT_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam int ROW_LIM = (ROWS < NUM_Y) ? ROWS : NUM_Y;
    localparam int COL_LIM = (COLS < NUM_X) ? COLS : NUM_X;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef t_word [NUM_X-1:0] t_xvec;
    typedef t_word [NUM_Y-1:0] t_yvec;

    typedef enum logic {
        REQ_WRITE     = 1'b0,
        REQ_TRANSFORM = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_IN_USE = 2'd0,
        CFG_COLS_IN_USE = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
        logic en_out;
    } t_pipe_ctrl;

endpackage

`default_nettype wire

/* sv/mvt_lane.sv */
`default_nettype none

module mvt_lane (
    input  wire logic                i_clk,
    input  wire mvt_pkg::t_pipe_ctrl i_ctrl,
    input  wire mvt_pkg::t_xvec      i_row,
    input  wire mvt_pkg::t_xvec      i_x,
    input  wire logic                i_used,
    output mvt_pkg::t_word           o_y,
    output logic                     o_sat
);
    import mvt_pkg::*;

    // products
    logic signed [PROD_W-1:0] r_prod [NUM_X];
    logic                     r_used2;
    // pair sums
    logic signed [PAIR_W-1:0] r_pair [NUM_X/2];
    logic                     r_used3;
    // full sum
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_used4;

    logic signed [Q_W-1:0]    q;
    logic                     ovf;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            for (int c = 0; c < NUM_X; c++) begin
                r_prod[c] <= $signed(i_row[c]) * $signed(i_x[c]);
            end
            r_used2 <= i_used;
        end
        if (i_ctrl.en3) begin
            for (int p = 0; p < NUM_X / 2; p++) begin
                r_pair[p] <= PAIR_W'(r_prod[2*p]) + PAIR_W'(r_prod[2*p+1]);
            end
            r_used3 <= r_used2;
        end
        if (i_ctrl.en4) begin
            r_sum   <= SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
            r_used4 <= r_used3;
        end
    end

    // floor shift, then clip to 32 bits
    always_comb begin
        q   = r_sum[SUM_W-1:Q_SHIFT];
        ovf = (q[Q_W-1:DATA_W-1] != '0) && (q[Q_W-1:DATA_W-1] != '1);
        if (!r_used4) begin
            o_y   = '0;
            o_sat = 1'b0;
        end else if (ovf) begin
            o_y   = q[Q_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            o_sat = 1'b1;
        end else begin
            o_y   = q[DATA_W-1:0];
            o_sat = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* sv/mvt_merge.sv */
`default_nettype none

module mvt_merge (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire mvt_pkg::t_pipe_ctrl      i_ctrl,
    input  wire logic                     i_valid,
    input  wire mvt_pkg::t_yvec           i_y,
    input  wire logic [mvt_pkg::NUM_Y-1:0] i_sat,
    output logic                          o_valid,
    output mvt_pkg::t_yvec                o_y,
    output logic                          o_sat
);
    import mvt_pkg::*;

    logic  r_valid;
    t_yvec r_y;
    logic  r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.en_out) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_out) begin
            r_y   <= i_y;
            r_sat <= |i_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_y     = r_y;
    assign o_sat   = r_sat;

endmodule

`default_nettype wire

/* sv/matrix_vector_transform_top.sv */
`default_nettype none

// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     req_type, entry_row/col/value, x0..x3
// output    out        o_out_valid / i_out_stall   y0..y3, saturated
// config    in         i_cfg_valid / o_cfg_ready   cfg_index, cfg_data
//
// one request per cycle while o_in_stall is low; a transform result goes through the capture register
// at accept, then 16 multipliers, two adder tree levels, clip and the output register
// write requests update the matrix at accept and give no result
// reset clears the matrix, sets rows and columns in use to 4 and empties the pipe
// each stage moves when the one after it is empty or moving, so bubbles close under stall

module matrix_vector_transform_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_req_type,
    input  wire logic [1:0]                      i_entry_row,
    input  wire logic [1:0]                      i_entry_col,
    input  wire logic signed [31:0]              i_entry_value,
    input  wire logic signed [31:0]              i_x0,
    input  wire logic signed [31:0]              i_x1,
    input  wire logic signed [31:0]              i_x2,
    input  wire logic signed [31:0]              i_x3,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [31:0]                   o_y0,
    output logic signed [31:0]                   o_y1,
    output logic signed [31:0]                   o_y2,
    output logic signed [31:0]                   o_y3,
    output logic                                 o_saturated,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mvt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mvt_pkg::CNT_W-1:0]       i_cfg_data
);
    import mvt_pkg::*;

    t_word            r_store [ROWS][COLS];
    logic [CNT_W-1:0] r_rows_in_use;
    logic [CNT_W-1:0] r_cols_in_use;

    logic             r_v1, r_v2, r_v3, r_v4;
    t_xvec            r_s1_row [NUM_Y];
    t_xvec            r_s1_x;
    logic             r_s1_used [NUM_Y];

    logic             n_v1;
    logic             ready_out, ready4, ready3, ready2, ready1;
    logic             accept;
    logic [CNT_W-1:0] nr, nc;
    t_xvec            x_in;
    t_pipe_ctrl       ctrl;
    t_yvec            lane_y;
    logic [NUM_Y-1:0] lane_sat;
    logic             out_valid;
    t_yvec            out_y;
    logic             out_sat;

    assign o_cfg_ready = 1'b1;

    assign ready_out = !out_valid || !i_out_stall;
    assign ready4    = !r_v4 || ready_out;
    assign ready3    = !r_v3 || ready4;
    assign ready2    = !r_v2 || ready3;
    assign ready1    = !r_v1 || ready2;

    assign o_in_stall = !ready1;
    assign accept     = i_in_valid && ready1;
    assign n_v1       = accept && (i_req_type == REQ_TRANSFORM);

    assign ctrl.en2    = ready2;
    assign ctrl.en3    = ready3;
    assign ctrl.en4    = ready4;
    assign ctrl.en_out = ready_out;

    assign nr = (r_rows_in_use > CNT_W'(ROW_LIM)) ? CNT_W'(ROW_LIM) : r_rows_in_use;
    assign nc = (r_cols_in_use > CNT_W'(COL_LIM)) ? CNT_W'(COL_LIM) : r_cols_in_use;

    assign x_in[0] = i_x0;
    assign x_in[1] = i_x1;
    assign x_in[2] = i_x2;
    assign x_in[3] = i_x3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CNT_W'(4);
            r_cols_in_use <= CNT_W'(4);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_data;
                CFG_COLS_IN_USE: r_cols_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    r_store[r][c] <= '0;
                end
            end
        end else if (accept && (i_req_type == REQ_WRITE)) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    if ((int'(i_entry_row) == r) && (int'(i_entry_col) == c)) begin
                        r_store[r][c] <= i_entry_value;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ready1) r_v1 <= n_v1;
            if (ready2) r_v2 <= r_v1;
            if (ready3) r_v3 <= r_v2;
            if (ready4) r_v4 <= r_v3;
        end
    end

    // capture stage: unused columns drop out as zero elements
    always_ff @(posedge i_clk) begin
        if (ready1) begin
            for (int c = 0; c < NUM_X; c++) begin
                r_s1_x[c] <= (CNT_W'(c) < nc) ? x_in[c] : '0;
            end
            for (int r = 0; r < NUM_Y; r++) begin
                r_s1_used[r] <= CNT_W'(r) < nr;
                for (int c = 0; c < NUM_X; c++) begin
                    if (r < ROWS && c < COLS) begin
                        r_s1_row[r][c] <= r_store[r % ROWS][c % COLS];
                    end else begin
                        r_s1_row[r][c] <= '0;
                    end
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_Y; g++) begin : g_lane
        mvt_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (ctrl),
            .i_row  (r_s1_row[g]),
            .i_x    (r_s1_x),
            .i_used (r_s1_used[g]),
            .o_y    (lane_y[g]),
            .o_sat  (lane_sat[g])
        );
    end

    mvt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_valid (r_v4),
        .i_y     (lane_y),
        .i_sat   (lane_sat),
        .o_valid (out_valid),
        .o_y     (out_y),
        .o_sat   (out_sat)
    );

    assign o_out_valid = out_valid;
    assign o_y0        = out_y[0];
    assign o_y1        = out_y[1];
    assign o_y2        = out_y[2];
    assign o_y3        = out_y[3];
    assign o_saturated = out_sat;

endmodule

`default_nettype wire
